[design/pat_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic alarm table package
// Shared types, field widths and codes for the periodic alarm table.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int HANDLER_W     = 8;
    localparam int PERIOD_W      = 32;
    localparam int TICK_MS_W     = 16;
    localparam int STATUS_W      = 2;

    localparam logic [TICK_MS_W-1:0] TICK_MS_RESET = 16'd10;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNLINK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [HANDLER_W-1:0] handler_id;
        logic [PERIOD_W-1:0]  interval_ms;
    } t_in_item;

    typedef struct packed {
        logic                 event_kind;
        logic [HANDLER_W-1:0] fired_handler;
        logic [STATUS_W-1:0]  status;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [HANDLER_W-1:0] handler;
        logic [PERIOD_W-1:0]  period;
        logic [PERIOD_W-1:0]  alarm;
    } t_slot;

endpackage

[design/pat_divider.sv]
// ----------------------------------------------------------------------------
// Periodic alarm table period divider
// Restoring divider that yields one quotient bit per cycle. A zero divisor
// gives an all-ones quotient.
// ----------------------------------------------------------------------------
module pat_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pat_pkg::PERIOD_W-1:0]     i_dividend,
    input  logic [pat_pkg::TICK_MS_W-1:0]    i_divisor,
    output logic                             o_busy,
    output logic [pat_pkg::PERIOD_W-1:0]     o_quotient
);

    localparam int QW = pat_pkg::PERIOD_W;
    localparam int DW = pat_pkg::TICK_MS_W;
    localparam int CNTW = $clog2(QW);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [QW-1:0]   r_quo;

    logic [DW:0]     w_shift;
    logic            w_bit;
    logic [DW:0]     w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[QW-1]};
        w_bit   = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNTW'(QW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_quo <= {r_quo[QW-2:0], w_bit};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[design/periodic_alarm_table_core.sv]
// ----------------------------------------------------------------------------
// Periodic alarm table core
// A register command offers its result once its search of the used slots ends
// and, unless the table is full, the divider is done; the walk can outlast it.
// Unlink and tick commands walk the used slots, a read and an event state per
// slot; a register or unlink with a null handler skips the walk, and output
// stalls delay all of these. One item is in work at a time; the next is taken
// once the core is idle again. Reset clears the enables, the used count, the
// tick count and sets tick_ms to 10; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module periodic_alarm_table_core #(
    parameter int NUM_SLOTS = pat_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pat_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pat_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [pat_pkg::TICK_MS_W-1:0] i_cfg_data
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic [pat_pkg::CMD_W-1:0]           r_cmd, n_cmd;
    logic [pat_pkg::HANDLER_W-1:0]       r_hid, n_hid;
    logic [CW-1:0]                       r_idx, n_idx;
    logic [CW-1:0]                       r_used, n_used;
    logic [NUM_SLOTS-1:0]                r_enabled, n_enabled;
    logic [pat_pkg::PERIOD_W-1:0]        r_count, n_count;
    logic [pat_pkg::TICK_MS_W-1:0]       r_tick_ms;
    logic [IW-1:0]                       r_target, n_target;
    logic                                r_append, n_append;
    logic                                r_pend_v, n_pend_v;
    logic [pat_pkg::HANDLER_W-1:0]       r_pend_h, n_pend_h;
    pat_pkg::t_out_item                  r_fin, n_fin;
    logic                                r_out_valid, n_out_valid;
    pat_pkg::t_out_item                  r_out_data, n_out_data;

    pat_pkg::t_slot                      r_mem [NUM_SLOTS];
    pat_pkg::t_slot                      r_rd;
    logic                                w_re;
    logic                                w_we;
    logic [IW-1:0]                       w_waddr;
    pat_pkg::t_slot                      w_wdata;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_div_start;
    logic                                w_div_busy;
    logic [pat_pkg::PERIOD_W-1:0]        w_quotient;
    logic                                w_slot_en;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_slot_en  = r_enabled[r_idx[IW-1:0]];

    pat_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_data.interval_ms),
        .i_divisor  (r_tick_ms),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_hid       = r_hid;
        n_idx       = r_idx;
        n_used      = r_used;
        n_enabled   = r_enabled;
        n_count     = r_count;
        n_target    = r_target;
        n_append    = r_append;
        n_pend_v    = r_pend_v;
        n_pend_h    = r_pend_h;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_idx[IW-1:0];
        w_wdata     = r_rd;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_in_data.cmd;
                    n_hid    = i_in_data.handler_id;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                    n_fin    = '{event_kind: pat_pkg::KIND_STATUS,
                                 fired_handler: i_in_data.handler_id,
                                 status: pat_pkg::ST_NULL, last: 1'b1};
                    priority if (i_in_data.cmd == pat_pkg::CMD_TICK) begin
                        n_count = r_count + 1'b1;
                        n_state = S_RD;
                    end else if (i_in_data.cmd == pat_pkg::CMD_REGISTER ||
                                 i_in_data.cmd == pat_pkg::CMD_UNLINK) begin
                        if (i_in_data.handler_id == '0) begin
                            n_state = S_FIN;
                        end else begin
                            w_div_start = (i_in_data.cmd == pat_pkg::CMD_REGISTER);
                            n_state     = S_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                if (r_idx < r_used) begin
                    w_re    = 1'b1;
                    n_state = S_EV;
                end else begin
                    priority if (r_cmd == pat_pkg::CMD_REGISTER) begin
                        if (r_used >= CW'(NUM_SLOTS)) begin
                            n_fin.status = pat_pkg::ST_FULL;
                            n_state      = S_FIN;
                        end else begin
                            n_target = r_used[IW-1:0];
                            n_append = 1'b1;
                            n_state  = S_DIVW;
                        end
                    end else if (r_cmd == pat_pkg::CMD_UNLINK) begin
                        n_fin.status = pat_pkg::ST_NOT_FOUND;
                        n_state      = S_FIN;
                    end else begin
                        if (r_pend_v) begin
                            n_fin    = '{event_kind: pat_pkg::KIND_FIRE,
                                         fired_handler: r_pend_h,
                                         status: pat_pkg::ST_DONE, last: 1'b1};
                            n_pend_v = 1'b0;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_EV: begin
                priority if (r_cmd == pat_pkg::CMD_REGISTER) begin
                    if (!w_slot_en || r_rd.handler == r_hid) begin
                        n_target = r_idx[IW-1:0];
                        n_append = 1'b0;
                        n_state  = S_DIVW;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else if (r_cmd == pat_pkg::CMD_UNLINK) begin
                    if (r_rd.handler == r_hid) begin
                        n_enabled[r_idx[IW-1:0]] = 1'b0;
                        w_we          = 1'b1;
                        w_wdata.alarm = '0;
                        n_fin.status  = pat_pkg::ST_DONE;
                        n_state       = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    if (w_slot_en && (r_count > r_rd.alarm)) begin
                        if (!r_pend_v || w_out_free) begin
                            if (r_pend_v) begin
                                n_out_valid = 1'b1;
                                n_out_data  = '{event_kind: pat_pkg::KIND_FIRE,
                                                fired_handler: r_pend_h,
                                                status: pat_pkg::ST_DONE, last: 1'b0};
                            end
                            w_we          = 1'b1;
                            w_wdata.alarm = r_rd.alarm + r_rd.period;
                            n_pend_v      = 1'b1;
                            n_pend_h      = r_rd.handler;
                            n_idx         = r_idx + 1'b1;
                            n_state       = S_RD;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_DIVW: begin
                if (!w_div_busy) begin
                    w_we      = 1'b1;
                    w_waddr   = r_target;
                    w_wdata   = '{handler: r_hid, period: w_quotient,
                                  alarm: r_count + w_quotient};
                    n_enabled[r_target] = 1'b1;
                    if (r_append) begin
                        n_used = r_used + 1'b1;
                    end
                    n_fin.status = pat_pkg::ST_DONE;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_fin;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_enabled   <= '0;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick_ms   <= pat_pkg::TICK_MS_RESET;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_enabled   <= n_enabled;
            r_count     <= n_count;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tick_ms <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_hid      <= n_hid;
        r_idx      <= n_idx;
        r_target   <= n_target;
        r_append   <= n_append;
        r_pend_h   <= n_pend_h;
        r_fin      <= n_fin;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(NUM_SLOTS))
        else $error("Used slot count exceeds the table size.");

    a_enabled_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enabled >> r_used) == '0)
        else $error("A slot beyond the used count is enabled.");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_cmd == pat_pkg::CMD_REGISTER) &&
                       (r_state == S_RD || r_state == S_EV || r_state == S_DIVW))
        else $error("Divider is busy outside a register command.");

    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cmd == pat_pkg::CMD_TICK) &&
                     (r_state == S_RD || r_state == S_EV))
        else $error("Pending fire result outside a tick walk.");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + 1'b1) &&
                                      ($past(r_state) == S_DIVW))
        else $error("Used slot count changed outside an append.");

endmodule
